>>> rtl/rfai_pkg.sv
// Shared definitions for the register file ALU interpreter.
// Command codes, field widths and the controller/datapath interface structs.
// No dependencies.
package rfai_pkg;

    localparam int CMD_W     = 4;
    localparam int REG_IDX_W = 5;
    localparam int IMM_W     = 32;
    localparam int VALUE_W   = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD = 4'd0;
    localparam logic [CMD_W-1:0] CMD_MOV  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_XCHG = 4'd2;
    localparam logic [CMD_W-1:0] CMD_ADD  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_SUB  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_MUL  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_DIV  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_MOD  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_AND  = 4'd8;
    localparam logic [CMD_W-1:0] CMD_OR   = 4'd9;
    localparam logic [CMD_W-1:0] CMD_XOR  = 4'd10;
    localparam logic [CMD_W-1:0] CMD_OUT  = 4'd11;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             capture;
        logic             load_imm;
        logic             wr_single;
        logic             wr_swap;
        logic             start_unit;
        logic             wr_unit;
        logic             emit_out;
        logic             emit_err;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_zero;
        logic unit_done;
        logic out_room;
    } t_dp_stat;

endpackage

>>> rtl/rfai_muldiv.sv
// Iterative multiply and divide unit, one bit per cycle.
// Used by rfai_dpath; depends on rfai_pkg for command codes.
module rfai_muldiv #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rfai_pkg::CMD_W-1:0] i_op,
    input  logic [DATA_WIDTH-1:0]      i_x,
    input  logic [DATA_WIDTH-1:0]      i_y,
    output logic                       o_done,
    output logic [DATA_WIDTH-1:0]      o_result
);
    import rfai_pkg::*;

    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic                  r_busy;
    logic [CW-1:0]         r_cnt;
    logic [DATA_WIDTH-1:0] r_acc;
    logic [DATA_WIDTH-1:0] r_a;
    logic [DATA_WIDTH-1:0] r_b;
    logic                  r_is_mul;
    logic                  r_is_mod;
    logic                  r_neg_q;
    logic                  r_neg_r;

    logic [DATA_WIDTH-1:0] mag_x;
    logic [DATA_WIDTH-1:0] mag_y;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;

    assign mag_x   = i_x[DATA_WIDTH-1] ? ('0 - i_x) : i_x;
    assign mag_y   = i_y[DATA_WIDTH-1] ? ('0 - i_y) : i_y;
    assign shifted = {r_acc, r_a[DATA_WIDTH-1]};
    assign diff    = shifted - {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DATA_WIDTH);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_is_mul <= (i_op == CMD_MUL);
            r_is_mod <= (i_op == CMD_MOD);
            r_neg_q  <= i_x[DATA_WIDTH-1] ^ i_y[DATA_WIDTH-1];
            r_neg_r  <= i_x[DATA_WIDTH-1];
            r_acc    <= '0;
            if (i_op == CMD_MUL) begin
                r_a <= i_x;
                r_b <= i_y;
            end else begin
                r_a <= mag_x;
                r_b <= mag_y;
            end
        end else if (r_busy && r_cnt != '0) begin
            if (r_is_mul) begin
                // Shift-and-add: the multiplicand moves left, the multiplier right.
                r_acc <= r_acc + (r_b[0] ? r_a : '0);
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
            end else if (!diff[DATA_WIDTH]) begin
                r_acc <= diff[DATA_WIDTH-1:0];
                r_a   <= {r_a[DATA_WIDTH-2:0], 1'b1};
            end else begin
                r_acc <= shifted[DATA_WIDTH-1:0];
                r_a   <= {r_a[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_busy && (r_cnt == '0);

    always_comb begin
        if (r_is_mul) begin
            o_result = r_acc;
        end else if (r_is_mod) begin
            o_result = r_neg_r ? ('0 - r_acc) : r_acc;
        end else begin
            o_result = r_neg_q ? ('0 - r_a) : r_a;
        end
    end

endmodule

>>> rtl/rfai_ctrl.sv
// Controller state machine for the register file ALU interpreter.
// Drives rfai_dpath through t_dp_cmd and reads t_dp_stat; depends on rfai_pkg.
module rfai_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [rfai_pkg::CMD_W-1:0] i_command,
    input  rfai_pkg::t_dp_stat         i_stat,
    output logic                       o_in_ready,
    output rfai_pkg::t_dp_cmd          o_cmd
);
    import rfai_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SWAP = 2'd2;
    localparam logic [1:0] S_UNIT = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CMD_W-1:0] r_op;
    logic [CMD_W-1:0] n_op;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        o_cmd      = '0;
        o_cmd.op   = r_op;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_op          = i_command;
                    if (i_command == CMD_LOAD) begin
                        o_cmd.load_imm = 1'b1;
                    end else if (i_command inside {[CMD_MOV:CMD_OUT]}) begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                case (r_op)
                    CMD_XCHG: begin
                        o_cmd.wr_single = 1'b1;
                        n_state         = S_SWAP;
                    end
                    CMD_OUT: begin
                        if (i_stat.out_room) begin
                            o_cmd.emit_out = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                    CMD_MUL: begin
                        o_cmd.start_unit = 1'b1;
                        n_state          = S_UNIT;
                    end
                    CMD_DIV, CMD_MOD: begin
                        if (i_stat.div_zero) begin
                            if (i_stat.out_room) begin
                                o_cmd.emit_err = 1'b1;
                                n_state        = S_IDLE;
                            end
                        end else begin
                            o_cmd.start_unit = 1'b1;
                            n_state          = S_UNIT;
                        end
                    end
                    default: begin
                        o_cmd.wr_single = 1'b1;
                        n_state         = S_IDLE;
                    end
                endcase
            end
            S_SWAP: begin
                o_cmd.wr_swap = 1'b1;
                n_state       = S_IDLE;
            end
            S_UNIT: begin
                if (i_stat.unit_done) begin
                    o_cmd.wr_unit = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= CMD_LOAD;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

endmodule

>>> rtl/rfai_dpath.sv
// Datapath: register file memory, operand registers, ALU and result register.
// Instantiates rfai_muldiv; depends on rfai_pkg.
module rfai_dpath #(
    parameter int NUM_REGS   = 26,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rfai_pkg::t_dp_cmd                     i_cmd,
    output rfai_pkg::t_dp_stat                    o_stat,
    input  logic [rfai_pkg::CMD_W-1:0]            i_command,
    input  logic [rfai_pkg::REG_IDX_W-1:0]        i_dest_reg,
    input  logic [rfai_pkg::REG_IDX_W-1:0]        i_src_a_reg,
    input  logic [rfai_pkg::REG_IDX_W-1:0]        i_src_b_reg,
    input  logic                                  i_three_operand,
    input  logic signed [rfai_pkg::IMM_W-1:0]     i_immediate,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic                                  o_status,
    output logic signed [rfai_pkg::VALUE_W-1:0]   o_value
);
    import rfai_pkg::*;

    // Only indices the five-bit fields can name need storage.
    localparam int MEM_DEPTH = (NUM_REGS < 2 ** REG_IDX_W) ? NUM_REGS : 2 ** REG_IDX_W;
    localparam int AW        = $clog2(MEM_DEPTH);

    function automatic logic in_range(input logic [REG_IDX_W-1:0] idx);
        return 32'(idx) < MEM_DEPTH;
    endfunction

    logic [DATA_WIDTH-1:0] r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]  r_valid;

    logic [REG_IDX_W-1:0]  r_d;
    logic [REG_IDX_W-1:0]  r_sa;
    logic [DATA_WIDTH-1:0] r_x_raw;
    logic [DATA_WIDTH-1:0] r_y_raw;
    logic                  r_x_ok;
    logic                  r_y_ok;
    logic                  r_out_valid;
    logic                  r_status;
    logic [VALUE_W-1:0]    r_value;

    logic                  alu_three;
    logic [REG_IDX_W-1:0]  rd_idx0;
    logic [REG_IDX_W-1:0]  rd_idx1;
    logic [DATA_WIDTH-1:0] x;
    logic [DATA_WIDTH-1:0] y;
    logic [DATA_WIDTH-1:0] alu_res;
    logic [DATA_WIDTH-1:0] unit_res;
    logic                  unit_done;
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  wr_idx;
    logic [DATA_WIDTH-1:0] wr_data;

    // Three-operand addressing applies to the arithmetic and logic commands only.
    assign alu_three = i_three_operand && (i_command inside {[CMD_ADD:CMD_XOR]});
    assign rd_idx0   = alu_three ? i_src_a_reg : i_dest_reg;
    assign rd_idx1   = alu_three ? i_src_b_reg : i_src_a_reg;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x_raw <= r_mem[rd_idx0[AW-1:0]];
            r_y_raw <= r_mem[rd_idx1[AW-1:0]];
            r_x_ok  <= in_range(rd_idx0) && r_valid[rd_idx0[AW-1:0]];
            r_y_ok  <= in_range(rd_idx1) && r_valid[rd_idx1[AW-1:0]];
            r_d     <= i_dest_reg;
            r_sa    <= i_src_a_reg;
        end
    end

    // Entries never written since reset read as zero.
    assign x = r_x_ok ? r_x_raw : '0;
    assign y = r_y_ok ? r_y_raw : '0;

    always_comb begin
        case (i_cmd.op)
            CMD_ADD: alu_res = x + y;
            CMD_SUB: alu_res = x - y;
            CMD_AND: alu_res = x & y;
            CMD_OR:  alu_res = x | y;
            CMD_XOR: alu_res = x ^ y;
            default: alu_res = y;
        endcase
    end

    rfai_muldiv #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.start_unit),
        .i_op     (i_cmd.op),
        .i_x      (x),
        .i_y      (y),
        .o_done   (unit_done),
        .o_result (unit_res)
    );

    always_comb begin
        wr_en = i_cmd.load_imm || i_cmd.wr_single || i_cmd.wr_swap || i_cmd.wr_unit;
        if (i_cmd.load_imm) begin
            wr_idx  = i_dest_reg;
            wr_data = DATA_WIDTH'(i_immediate);
        end else if (i_cmd.wr_swap) begin
            wr_idx  = r_sa;
            wr_data = x;
        end else if (i_cmd.wr_unit) begin
            wr_idx  = r_d;
            wr_data = unit_res;
        end else begin
            wr_idx  = r_d;
            wr_data = alu_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && in_range(wr_idx)) begin
            r_mem[wr_idx[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en && in_range(wr_idx)) begin
            r_valid[wr_idx[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_out || i_cmd.emit_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_out || i_cmd.emit_err) begin
            r_status <= i_cmd.emit_err;
            r_value  <= i_cmd.emit_err ? '0 : VALUE_W'(x);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_value          = r_value;
    assign o_stat.div_zero  = (y == '0);
    assign o_stat.unit_done = unit_done;
    assign o_stat.out_room  = !r_out_valid || i_out_ready;

endmodule

>>> rtl/register_file_alu_interpreter_unit.sv
// Top level of the register file ALU interpreter.
// Instantiates rfai_ctrl and rfai_dpath; depends on rfai_pkg.
//
// This block executes one decoded instruction item at a time on NUM_REGS
// registers of DATA_WIDTH bits, all zero after reset. An item is taken when
// o_in_ready is high, which is whenever the previous item has finished its
// work, even if a result still sits in the output register. LOAD and the
// unused command codes finish in the cycle they are taken. MOV, ADD, SUB,
// AND, OR, XOR, OUT and a DIV or MOD by zero first read the two operands
// from the register file memory and then execute. XCHG writes its second
// register in the S_SWAP state, since the memory has a single write port and
// the swap needs two writes. MUL, DIV and MOD go through a shared shift-add
// and restoring-divide unit that retires one bit a cycle; this unit sets the
// worst-case rate. OUT and the divide-by-zero error each give one result
// item; an error carries status 1 and value 0 and leaves the destination
// unchanged. When the output register is full and not being taken, an item
// that must give a result waits until it drains.
module register_file_alu_interpreter_unit #(
    parameter int NUM_REGS   = 26,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [rfai_pkg::CMD_W-1:0]            i_command,
    input  logic [rfai_pkg::REG_IDX_W-1:0]        i_dest_reg,
    input  logic [rfai_pkg::REG_IDX_W-1:0]        i_src_a_reg,
    input  logic [rfai_pkg::REG_IDX_W-1:0]        i_src_b_reg,
    input  logic                                  i_three_operand,
    input  logic signed [rfai_pkg::IMM_W-1:0]     i_immediate,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_status,
    output logic signed [rfai_pkg::VALUE_W-1:0]   o_value
);
    import rfai_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    rfai_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_stat     (dp_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd)
    );

    rfai_dpath #(
        .NUM_REGS   (NUM_REGS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_command       (i_command),
        .i_dest_reg      (i_dest_reg),
        .i_src_a_reg     (i_src_a_reg),
        .i_src_b_reg     (i_src_b_reg),
        .i_three_operand (i_three_operand),
        .i_immediate     (i_immediate),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_value         (o_value)
    );

    // At most one write, unit start or result load is commanded in a cycle.
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.load_imm, dp_cmd.wr_single, dp_cmd.wr_swap, dp_cmd.wr_unit,
                  dp_cmd.start_unit, dp_cmd.emit_out, dp_cmd.emit_err}))
        else $error("more than one datapath action in a cycle");

    // Once the multiply/divide unit starts, no new item may be taken.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.start_unit |=> !o_in_ready)
        else $error("item accepted while the multiply/divide unit runs");

    // A result is only loaded when the output register can take it.
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.emit_out || dp_cmd.emit_err) |-> dp_stat.out_room)
        else $error("result loaded over an untaken result");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the register file ALU interpreter.
// Holds a driver, a result monitor and a predictor of the register file in one module.
// Depends on rfai_pkg and register_file_alu_interpreter_unit.
module tb_top;
    import rfai_pkg::*;

    localparam int NUM_REGS   = 26;
    localparam int DATA_WIDTH = 32;

    // Command codes 12 to 15 have no meaning; the block must swallow them silently.
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd12;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;
    localparam int MAX_REG_IDX = 2 ** REG_IDX_W - 1;

    localparam logic [VALUE_W-1:0] MIN_VAL = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] MAX_VAL = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    localparam int RANDOM_ITEMS   = 600;
    localparam int CALM_ITEMS     = 100;   // final stretch with no idling on either side
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off that backs up the block
    localparam int DRAIN_CYCLES   = 80;    // settle time after the last result
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either channel

    // One decoded instruction plus two pacing flags that never reach the block.
    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [REG_IDX_W-1:0] dst;
        logic [REG_IDX_W-1:0] src_a;
        logic [REG_IDX_W-1:0] src_b;
        logic                 three;
        logic [IMM_W-1:0]     imm;
        logic                 drain_first;  // wait until every result is back
        logic                 hold_out;     // ask the receiver for a long hold-off
    } t_instr;

    typedef struct packed {
        logic               status;
        logic [VALUE_W-1:0] value;
    } t_result;

    logic   i_clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   out_ready = 1'b0;
    t_instr cur_instr = '0;

    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_status;
    logic [VALUE_W-1:0] o_value;

    t_instr  instr_queue[$];
    t_result pending_results[$];

    // Shadow copy of the block's registers, updated as each item is accepted.
    logic [DATA_WIDTH-1:0] shadow_regs [NUM_REGS];

    int n_errors    = 0;
    int n_accepted  = 0;
    int total_items = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int hold_left   = 0;
    int hold_req    = 0;
    int hold_ack    = 0;
    int idle_cnt    = 0;
    int rx_cycles   = 0;
    bit idle_on     = 1'b1;
    bit rx_idle_on  = 1'b1;
    bit calm        = 1'b0;
    bit next_drain  = 1'b0;
    bit next_hold   = 1'b0;

    register_file_alu_interpreter_unit #(
        .NUM_REGS   (NUM_REGS),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (cur_instr.cmd),
        .i_dest_reg      (cur_instr.dst),
        .i_src_a_reg     (cur_instr.src_a),
        .i_src_b_reg     (cur_instr.src_b),
        .i_three_operand (cur_instr.three),
        .i_immediate     (cur_instr.imm),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_status        (o_status),
        .o_value         (o_value)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Indexes past the last register read as zero and swallow writes.
    function automatic logic [DATA_WIDTH-1:0] read_reg(logic [REG_IDX_W-1:0] idx);
        if (idx < NUM_REGS) begin
            return shadow_regs[idx];
        end
        return '0;
    endfunction

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_WIDTH-1:0] v);
        if (idx < NUM_REGS) begin
            shadow_regs[idx] = v;
        end
    endtask

    function automatic logic [DATA_WIDTH-1:0] magnitude(logic [DATA_WIDTH-1:0] v);
        return v[DATA_WIDTH-1] ? -v : v;
    endfunction

    // Applies one accepted instruction to the shadow registers and queues the
    // result item it gives, if any.
    task automatic execute_instr(t_instr it);
        logic [DATA_WIDTH-1:0] x;
        logic [DATA_WIDTH-1:0] y;
        logic [DATA_WIDTH-1:0] r;
        logic [DATA_WIDTH-1:0] q;
        logic [DATA_WIDTH-1:0] m;
        x = '0;
        y = '0;
        r = '0;
        case (it.cmd)
            CMD_LOAD: begin
                write_reg(it.dst, it.imm);
            end
            CMD_MOV: begin
                write_reg(it.dst, read_reg(it.src_a));
            end
            CMD_XCHG: begin
                x = read_reg(it.dst);
                y = read_reg(it.src_a);
                write_reg(it.dst, y);
                write_reg(it.src_a, x);
            end
            CMD_OUT: begin
                pending_results.push_back('{status: 1'b0, value: read_reg(it.dst)});
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_AND, CMD_OR, CMD_XOR: begin
                if (it.three) begin
                    x = read_reg(it.src_a);
                    y = read_reg(it.src_b);
                end else begin
                    x = read_reg(it.dst);
                    y = read_reg(it.src_a);
                end
                if ((it.cmd == CMD_DIV || it.cmd == CMD_MOD) && y == '0) begin
                    // Division by zero: destination untouched, one error item.
                    pending_results.push_back('{status: 1'b1, value: '0});
                end else begin
                    // Quotient and remainder are built from magnitudes so that the
                    // most negative value divided by minus one wraps cleanly.
                    q = magnitude(x) / magnitude(y);
                    m = magnitude(x) % magnitude(y);
                    case (it.cmd)
                        CMD_ADD: r = x + y;
                        CMD_SUB: r = x - y;
                        CMD_MUL: r = x * y;
                        CMD_DIV: r = (x[DATA_WIDTH-1] != y[DATA_WIDTH-1]) ? -q : q;
                        CMD_MOD: r = x[DATA_WIDTH-1] ? -m : m;
                        CMD_AND: r = x & y;
                        CMD_OR:  r = x | y;
                        default: r = x ^ y;
                    endcase
                    write_reg(it.dst, r);
                end
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_instr(logic [CMD_W-1:0] cmd, int dst, int src_a, int src_b,
                             bit three, logic [IMM_W-1:0] imm);
        t_instr it;
        it.cmd         = cmd;
        it.dst         = REG_IDX_W'(dst);
        it.src_a       = REG_IDX_W'(src_a);
        it.src_b       = REG_IDX_W'(src_b);
        it.three       = three;
        it.imm         = imm;
        it.drain_first = next_drain;
        it.hold_out    = next_hold;
        next_drain     = 1'b0;
        next_hold      = 1'b0;
        instr_queue.push_back(it);
    endtask

    // Mostly real registers, now and then an index past the end of the file.
    function automatic int pick_reg();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(NUM_REGS, MAX_REG_IDX);
        end
        return $urandom_range(0, NUM_REGS - 1);
    endfunction

    function automatic logic [IMM_W-1:0] pick_imm();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return ALL_ONES;
            2: return MIN_VAL;
            3: return MAX_VAL;
            4: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: directed cases, pressure phases, then random items.
    // ------------------------------------------------------------------
    initial begin
        int n_random;
        int pick;
        int z;
        int op_pick;
        logic [CMD_W-1:0] cmd;

        foreach (shadow_regs[i]) begin
            shadow_regs[i] = '0;
        end

        // Registers start at zero, and an index past the end reads as zero.
        add_instr(CMD_OUT,  0, 0, 0, 1'b0, '0);
        add_instr(CMD_LOAD, 1, 0, 0, 1'b0, MAX_VAL);
        add_instr(CMD_LOAD, 2, 0, 0, 1'b0, MIN_VAL);
        add_instr(CMD_LOAD, 3, 0, 0, 1'b0, ALL_ONES);
        add_instr(CMD_LOAD, MAX_REG_IDX, MAX_REG_IDX, MAX_REG_IDX, 1'b1, 32'd123);
        add_instr(CMD_OUT,  MAX_REG_IDX, 0, 0, 1'b0, '0);
        // Wrapping add, and the most negative value divided by minus one.
        add_instr(CMD_ADD,  4, 1, 1, 1'b1, '0);
        add_instr(CMD_DIV,  5, 2, 3, 1'b1, '0);
        add_instr(CMD_MOD,  6, 2, 3, 1'b1, '0);
        // Division by zero in both forms; the second divisor is out of range.
        add_instr(CMD_DIV,  1, 0, 0, 1'b0, '0);
        add_instr(CMD_MOD,  7, 3, NUM_REGS + 4, 1'b1, '0);
        add_instr(CMD_XCHG, 1, 2, 0, 1'b0, '0);
        add_instr(CMD_MOV,  NUM_REGS - 1, 1, 0, 1'b0, '0);
        add_instr(CMD_SUB,  NUM_REGS - 1, 3, 0, 1'b0, '0);
        add_instr(CMD_MUL,  8, 1, 3, 1'b1, '0);
        add_instr(CMD_AND,  9, 3, 2, 1'b1, '0);
        add_instr(CMD_OR,   9, 4, 0, 1'b0, '0);
        add_instr(CMD_XOR,  10, 9, 3, 1'b1, '0);
        add_instr(CMD_UNUSED_LO, 11, 12, 13, 1'b1, ALL_ONES);
        add_instr(CMD_UNUSED_HI, MAX_REG_IDX, MAX_REG_IDX, MAX_REG_IDX, 1'b0, MIN_VAL);
        // Negative dividend divided by minus two: the remainder is zero.
        add_instr(CMD_MOD,  11, 8, 4, 1'b1, '0);
        add_instr(CMD_DIV,  3, 2, 0, 1'b0, '0);
        add_instr(CMD_OUT,  NUM_REGS - 1, 0, 0, 1'b0, '0);
        add_instr(CMD_OUT,  11, 0, 0, 1'b0, '0);

        // The sender waits for every result, then the receiver holds off for a
        // long time while a run of OUT items fills the output register and
        // stalls the input side.
        next_drain = 1'b1;
        next_hold  = 1'b1;
        add_instr(CMD_OUT, 5, 0, 0, 1'b0, '0);
        for (int i = 0; i < 12; i++) begin
            add_instr(CMD_OUT, i, 0, 0, 1'b0, '0);
        end

        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            if (n_random == RANDOM_ITEMS / 2) begin
                next_drain = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // Load a zero and divide by it, then show a randomly chosen register.
                z = $urandom_range(0, NUM_REGS - 1);
                cmd = $urandom_range(0, 1) ? CMD_DIV : CMD_MOD;
                add_instr(CMD_LOAD, z, pick_reg(), pick_reg(), 1'($urandom_range(0, 1)), '0);
                if ($urandom_range(0, 1)) begin
                    add_instr(cmd, pick_reg(), pick_reg(), z, 1'b1, pick_imm());
                end else begin
                    add_instr(cmd, pick_reg(), z, pick_reg(), 1'b0, pick_imm());
                end
                add_instr(CMD_OUT, pick_reg(), pick_reg(), pick_reg(), 1'b0, pick_imm());
                n_random += 3;
            end else begin
                op_pick = $urandom_range(0, 99);
                if (op_pick < 15) begin
                    cmd = CMD_LOAD;
                end else if (op_pick < 35) begin
                    cmd = CMD_OUT;
                end else if (op_pick < 38) begin
                    cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
                end else begin
                    cmd = CMD_W'($urandom_range(CMD_MOV, CMD_XOR));
                end
                add_instr(cmd, pick_reg(), pick_reg(), pick_reg(),
                          1'($urandom_range(0, 1)), pick_imm());
                // Unused codes are ignored by the block and do not count.
                if (cmd < CMD_UNUSED_LO) begin
                    n_random++;
                end
            end
        end
        total_items = instr_queue.size();

        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;

        while (instr_queue.size() != 0 || in_valid || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver. The predictor runs on the item accepted at this edge, then the
    // next item, a gap or nothing is presented.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit start_gap;
        bit can_send;
        start_gap = 1'b0;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && o_in_ready) begin
                execute_instr(cur_instr);
                n_accepted++;
                // Switch idling on or off in blocks so that both dense and
                // sparse stretches occur.
                if (n_accepted % 40 == 0) begin
                    idle_on = 1'($urandom_range(0, 1));
                end
                start_gap = !calm && idle_on && ($urandom_range(0, 3) == 0);
                calm <= (n_accepted >= total_items - CALM_ITEMS);
            end
            can_send = instr_queue.size() != 0 &&
                       (!instr_queue[0].drain_first || pending_results.size() == 0);
            if (in_valid && !o_in_ready) begin
                // Item still offered; valid and payload stay put.
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (start_gap) begin
                gap_left <= $urandom_range(0, 16);
                in_valid <= 1'b0;
            end else if (can_send) begin
                if (instr_queue[0].hold_out) begin
                    hold_req <= hold_req + 1;
                end
                cur_instr <= instr_queue.pop_front();
                in_valid  <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver ready. A hold request from the driver forces a long hold-off;
    // otherwise ready drops in short random bursts.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end else begin
            rx_cycles <= rx_cycles + 1;
            if (rx_cycles % 200 == 0) begin
                rx_idle_on <= 1'($urandom_range(0, 1));
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (hold_ack != hold_req) begin
                hold_ack  <= hold_req;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end else if (!calm && rx_idle_on && $urandom_range(0, 4) == 0) begin
                stall_left <= $urandom_range(0, 16);
                out_ready  <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each accepted result item is checked against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    task automatic log_mismatch(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        t_result exp_res;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                log_mismatch($sformatf("result with nothing pending: status %0b value %h",
                                       o_status, o_value));
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status) begin
                    log_mismatch($sformatf("status %0b, predicted %0b",
                                           o_status, exp_res.status));
                end
                if (o_value !== exp_res.value) begin
                    log_mismatch($sformatf("value %h, predicted %h", o_value, exp_res.value));
                end
            end
        end
    end

    // Watchdog: while work is outstanding, some item must move now and then.
    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (instr_queue.size() == 0 && !in_valid && pending_results.size() == 0)) begin
                idle_cnt <= 0;
            end else begin
                idle_cnt <= idle_cnt + 1;
            end
            if (idle_cnt >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule

>>> files.f
rtl/rfai_pkg.sv
rtl/rfai_muldiv.sv
rtl/rfai_ctrl.sv
rtl/rfai_dpath.sv
rtl/register_file_alu_interpreter_unit.sv
tb/tb_top.sv
